@@ hdl/pnrt_pkg.sv @@
// Shared types, widths and helpers for the point/normal rigid transform unit.
// Used by the channel interfaces, the row datapath and the top level.
// Depends on nothing.
package pnrt_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int POS_WIDTH  = 32;
	localparam int NORM_WIDTH = 16;
	localparam int COEF_FRAC  = COEF_WIDTH - 2;
	localparam int CURV_WIDTH = 32;
	localparam int CHAN_WIDTH = 8;

	localparam int ROW_WIDTH   = 3 * COEF_WIDTH;
	localparam int SHIFT_WIDTH = POS_WIDTH;
	localparam int CFG_WIDTH   = ROW_WIDTH;
	localparam int CFG_IDX_W   = 3;

	// datapath widths: product, sum of three, rounded, rounded plus shift
	localparam int PROD_P_W = POS_WIDTH + COEF_WIDTH;
	localparam int SUM_P_W  = PROD_P_W + 2;
	localparam int RND_P_W  = SUM_P_W - COEF_FRAC;
	localparam int TRN_P_W  = RND_P_W + 1;
	localparam int PROD_N_W = NORM_WIDTH + COEF_WIDTH;
	localparam int SUM_N_W  = PROD_N_W + 2;
	localparam int RND_N_W  = SUM_N_W - COEF_FRAC;

	typedef logic signed [COEF_WIDTH-1:0]  coef_t;
	typedef logic signed [POS_WIDTH-1:0]   pos_t;
	typedef logic signed [NORM_WIDTH-1:0]  norm_t;
	typedef logic        [ROW_WIDTH-1:0]   row_t;
	typedef logic signed [SHIFT_WIDTH-1:0] shift_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0,
		REG_ROW1,
		REG_ROW2,
		REG_SHIFT_X,
		REG_SHIFT_Y,
		REG_SHIFT_Z
	} cfg_reg_t;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0]  pos_x;
		logic signed [POS_WIDTH-1:0]  pos_y;
		logic signed [POS_WIDTH-1:0]  pos_z;
		logic signed [NORM_WIDTH-1:0] norm_x;
		logic signed [NORM_WIDTH-1:0] norm_y;
		logic signed [NORM_WIDTH-1:0] norm_z;
		logic [CURV_WIDTH-1:0]        curvature_bits;
		logic [CHAN_WIDTH-1:0]        red;
		logic [CHAN_WIDTH-1:0]        green;
		logic [CHAN_WIDTH-1:0]        blue;
	} point_in_t;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0]  out_x;
		logic signed [POS_WIDTH-1:0]  out_y;
		logic signed [POS_WIDTH-1:0]  out_z;
		logic signed [NORM_WIDTH-1:0] out_norm_x;
		logic signed [NORM_WIDTH-1:0] out_norm_y;
		logic signed [NORM_WIDTH-1:0] out_norm_z;
		logic [CURV_WIDTH-1:0]        out_curvature_bits;
		logic [CHAN_WIDTH-1:0]        out_red;
		logic [CHAN_WIDTH-1:0]        out_green;
		logic [CHAN_WIDTH-1:0]        out_blue;
	} point_out_t;

	typedef struct packed {
		logic [CURV_WIDTH-1:0] curvature_bits;
		logic [CHAN_WIDTH-1:0] red;
		logic [CHAN_WIDTH-1:0] green;
		logic [CHAN_WIDTH-1:0] blue;
	} pass_t;

	// load enables of the three pipeline stages
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} stage_en_t;

	// identity row r: 1.0 on the diagonal
	function automatic row_t row_reset(input int unsigned r);
		row_t one;
		one = ROW_WIDTH'(1) << COEF_FRAC;
		return one << (r * COEF_WIDTH);
	endfunction

	function automatic pos_t sat_pos(input logic signed [TRN_P_W-1:0] v);
		logic [TRN_P_W-POS_WIDTH:0] hi;
		hi = v[TRN_P_W-1:POS_WIDTH-1];
		if (&hi || ~|hi)
			return v[POS_WIDTH-1:0];
		return {v[TRN_P_W-1], {(POS_WIDTH-1){~v[TRN_P_W-1]}}};
	endfunction

	function automatic norm_t sat_norm(input logic signed [RND_N_W-1:0] v);
		logic [RND_N_W-NORM_WIDTH:0] hi;
		hi = v[RND_N_W-1:NORM_WIDTH-1];
		if (&hi || ~|hi)
			return v[NORM_WIDTH-1:0];
		return {v[RND_N_W-1], {(NORM_WIDTH-1){~v[RND_N_W-1]}}};
	endfunction

endpackage

@@ hdl/pnrt_if.sv @@
// Valid/ready channel interfaces carrying input points and transformed points.
// Depends on pnrt_pkg for the payload structs.
interface pnrt_in_if;
	logic                 valid;
	logic                 ready;
	pnrt_pkg::point_in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pnrt_out_if;
	logic                 valid;
	logic                 ready;
	pnrt_pkg::point_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/pnrt_row.sv @@
// One matrix row of the transform: three-stage multiply, sum/round, shift/saturate.
// Produces one position and one normal component. Depends on pnrt_pkg.
module pnrt_row (
	input  logic                clk,
	input  pnrt_pkg::stage_en_t ctl,
	input  pnrt_pkg::pos_t      pos [3],
	input  pnrt_pkg::norm_t     norm [3],
	input  pnrt_pkg::row_t      coeffs,
	input  pnrt_pkg::shift_t    shift,
	output pnrt_pkg::pos_t      pos_out,
	output pnrt_pkg::norm_t     norm_out
);

	localparam logic signed [pnrt_pkg::SUM_P_W-1:0] HALF_P =
		pnrt_pkg::SUM_P_W'(1) << (pnrt_pkg::COEF_FRAC - 1);
	localparam logic signed [pnrt_pkg::SUM_N_W-1:0] HALF_N =
		pnrt_pkg::SUM_N_W'(1) << (pnrt_pkg::COEF_FRAC - 1);

	pnrt_pkg::coef_t                            coef [3];
	logic signed [pnrt_pkg::PROD_P_W-1:0]       prod_p_s1 [3];
	logic signed [pnrt_pkg::PROD_N_W-1:0]       prod_n_s1 [3];
	logic signed [pnrt_pkg::SUM_P_W-1:0]        sum_p_s2;
	logic signed [pnrt_pkg::SUM_N_W-1:0]        sum_n_s2;
	logic signed [pnrt_pkg::SUM_P_W-1:0]        shr_p;
	logic signed [pnrt_pkg::SUM_N_W-1:0]        shr_n;
	logic signed [pnrt_pkg::RND_P_W-1:0]        rnd_p;
	logic signed [pnrt_pkg::RND_N_W-1:0]        rnd_n;
	logic signed [pnrt_pkg::TRN_P_W-1:0]        trn_p;
	pnrt_pkg::pos_t                             pos_s3;
	pnrt_pkg::norm_t                            norm_s3;

	always_comb begin
		for (int c = 0; c < 3; c++)
			coef[c] = coeffs[c*pnrt_pkg::COEF_WIDTH +: pnrt_pkg::COEF_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			for (int c = 0; c < 3; c++) begin
				prod_p_s1[c] <= pnrt_pkg::PROD_P_W'(pos[c]) * pnrt_pkg::PROD_P_W'(coef[c]);
				prod_n_s1[c] <= pnrt_pkg::PROD_N_W'(norm[c]) * pnrt_pkg::PROD_N_W'(coef[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			sum_p_s2 <= pnrt_pkg::SUM_P_W'(prod_p_s1[0]) + pnrt_pkg::SUM_P_W'(prod_p_s1[1])
				+ pnrt_pkg::SUM_P_W'(prod_p_s1[2]) + HALF_P;
			sum_n_s2 <= pnrt_pkg::SUM_N_W'(prod_n_s1[0]) + pnrt_pkg::SUM_N_W'(prod_n_s1[1])
				+ pnrt_pkg::SUM_N_W'(prod_n_s1[2]) + HALF_N;
		end
	end

	always_comb begin
		shr_p = sum_p_s2 >>> pnrt_pkg::COEF_FRAC;
		shr_n = sum_n_s2 >>> pnrt_pkg::COEF_FRAC;
		rnd_p = shr_p[pnrt_pkg::RND_P_W-1:0];
		rnd_n = shr_n[pnrt_pkg::RND_N_W-1:0];
		trn_p = pnrt_pkg::TRN_P_W'(rnd_p) + pnrt_pkg::TRN_P_W'(shift);
	end

	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			pos_s3  <= pnrt_pkg::sat_pos(trn_p);
			norm_s3 <= pnrt_pkg::sat_norm(rnd_n);
		end
	end

	assign pos_out  = pos_s3;
	assign norm_out = norm_s3;

endmodule

@@ hdl/point_normal_rigid_transform_unit.sv @@
// Top level of the point/normal rigid transform unit: configuration registers,
// pipeline valid tracking and three row datapaths. Depends on pnrt_pkg,
// pnrt_if and pnrt_row.
//
// Usage:
// - pt_in (valid/ready) carries one point per request: Q16.16 position, Q1.14
//   normal, curvature bits and colour. pt_out returns one transformed point per
//   request, in order: position through the 3x3 matrix plus translation,
//   normal through the matrix alone, both rounded half-up and saturated;
//   curvature and colour unchanged.
// - Configuration: cfg_we/cfg_index/cfg_wdata write registers 0..5 (three
//   matrix rows, then translation x, y, z). Unknown indexes are dropped. Write
//   only while no request is in flight.
// - Stages: multiply, sum and round, translate and saturate, each registered.
//   Throughput: one request per cycle while the receiver holds pt_out.ready high,
//   set by the nine position and nine normal multipliers working in parallel.
// - Reset: pipeline empties, matrix returns to identity, translation to zero.
// - Receiver stall: the output stage holds; each stage still takes a request
//   while any stage ahead of it is empty, so bubbles are squeezed out and
//   pt_in.ready drops only when all three stages are full.
module point_normal_rigid_transform_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	pnrt_in_if.sink                           pt_in,
	pnrt_out_if.source                        pt_out,
	input  logic                              cfg_we,
	input  logic [pnrt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pnrt_pkg::CFG_WIDTH-1:0]    cfg_wdata
);

	pnrt_pkg::row_t      row_q [3];
	pnrt_pkg::shift_t    shift_q [3];
	logic                v_s1, v_s2, v_s3;
	logic                rdy1, rdy2, rdy3;
	pnrt_pkg::stage_en_t ctl;
	pnrt_pkg::pass_t     pass_s1, pass_s2, pass_s3;
	pnrt_pkg::pos_t      pos [3];
	pnrt_pkg::norm_t     norm [3];
	pnrt_pkg::pos_t      pos_res [3];
	pnrt_pkg::norm_t     norm_res [3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				row_q[r]   <= pnrt_pkg::row_reset(r);
				shift_q[r] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				pnrt_pkg::REG_ROW0:    row_q[0]   <= cfg_wdata;
				pnrt_pkg::REG_ROW1:    row_q[1]   <= cfg_wdata;
				pnrt_pkg::REG_ROW2:    row_q[2]   <= cfg_wdata;
				pnrt_pkg::REG_SHIFT_X: shift_q[0] <= cfg_wdata[pnrt_pkg::SHIFT_WIDTH-1:0];
				pnrt_pkg::REG_SHIFT_Y: shift_q[1] <= cfg_wdata[pnrt_pkg::SHIFT_WIDTH-1:0];
				pnrt_pkg::REG_SHIFT_Z: shift_q[2] <= cfg_wdata[pnrt_pkg::SHIFT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the one ahead moves on
	assign rdy3    = !v_s3 || pt_out.ready;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign ctl.en1 = rdy1 && pt_in.valid;
	assign ctl.en2 = rdy2 && v_s1;
	assign ctl.en3 = rdy3 && v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= pt_in.valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en1)
			pass_s1 <= '{curvature_bits: pt_in.data.curvature_bits, red: pt_in.data.red,
				green: pt_in.data.green, blue: pt_in.data.blue};
		if (ctl.en2)
			pass_s2 <= pass_s1;
		if (ctl.en3)
			pass_s3 <= pass_s2;
	end

	assign pos[0]  = pt_in.data.pos_x;
	assign pos[1]  = pt_in.data.pos_y;
	assign pos[2]  = pt_in.data.pos_z;
	assign norm[0] = pt_in.data.norm_x;
	assign norm[1] = pt_in.data.norm_y;
	assign norm[2] = pt_in.data.norm_z;

	for (genvar r = 0; r < 3; r++) begin : g_row
		pnrt_row u_row (
			.clk      (clk),
			.ctl      (ctl),
			.pos      (pos),
			.norm     (norm),
			.coeffs   (row_q[r]),
			.shift    (shift_q[r]),
			.pos_out  (pos_res[r]),
			.norm_out (norm_res[r])
		);
	end

	assign pt_in.ready = rdy1;
	assign pt_out.valid = v_s3;
	assign pt_out.data = '{
		out_x:              pos_res[0],
		out_y:              pos_res[1],
		out_z:              pos_res[2],
		out_norm_x:         norm_res[0],
		out_norm_y:         norm_res[1],
		out_norm_z:         norm_res[2],
		out_curvature_bits: pass_s3.curvature_bits,
		out_red:            pass_s3.red,
		out_green:          pass_s3.green,
		out_blue:           pass_s3.blue
	};

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> pt_in.ready)
		else $error("input stalled while output stage is empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pt_in.valid && pt_in.ready |=> v_s1)
		else $error("accepted request not captured in first stage");

	a_s2_drains: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !v_s3 |=> v_s3)
		else $error("second stage did not advance into empty output stage");

endmodule

@@ tb/point_normal_rigid_transform_unit_tb.sv @@
// Testbench for point_normal_rigid_transform_unit: streams points through the
// valid/ready channels and checks each transformed point against its own fixed-point
// model of the 3x3 matrix and translation. Depends on pnrt_pkg, pnrt_if and the DUT.
module point_normal_rigid_transform_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LATENCY      = 3;
	localparam int          CYCLE_LIMIT  = 200_000;
	localparam int          RANDOM_ITEMS = 530;
	localparam int          PHASES       = 8;
	localparam int          REPORT_LIMIT = 10;

	localparam logic [pnrt_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [pnrt_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

	localparam pnrt_pkg::coef_t  COEF_ONE      = 16'sd16384;
	localparam pnrt_pkg::coef_t  COEF_MOST_POS = 16'sh7fff;
	localparam pnrt_pkg::coef_t  COEF_MOST_NEG = 16'sh8000;
	localparam pnrt_pkg::pos_t   POS_MAX       = 32'sh7fff_ffff;
	localparam pnrt_pkg::pos_t   POS_MIN       = 32'sh8000_0000;
	localparam pnrt_pkg::norm_t  NORM_MAX      = 16'sh7fff;
	localparam pnrt_pkg::norm_t  NORM_MIN      = 16'sh8000;
	localparam pnrt_pkg::row_t   ROW_ZERO      = '0;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pnrt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pnrt_pkg::CFG_WIDTH-1:0]  cfg_wdata;

	pnrt_in_if  pt_in ();
	pnrt_out_if pt_out ();

	point_normal_rigid_transform_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_in     (pt_in),
		.pt_out    (pt_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pnrt_pkg::row_t        matrix_row [3];
	pnrt_pkg::shift_t      translation [3];
	pnrt_pkg::point_out_t  expected_points [$];

	int          failures    = 0;
	int          cycle_count = 0;
	int          burst_left  = 0;
	int          max_gap     = 0;
	bit          gaps_on     = 1'b0;
	bit          stall_on    = 1'b0;
	int          ready_run   = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d points outstanding", cycle_count,
				expected_points.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic longint clamp(input longint v, input int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint round_half_up(input longint sum);
		return (sum + (longint'(1) <<< (pnrt_pkg::COEF_FRAC - 1))) >>> pnrt_pkg::COEF_FRAC;
	endfunction

	function automatic pnrt_pkg::point_out_t transform_point(input pnrt_pkg::point_in_t p);
		pnrt_pkg::point_out_t r;
		longint     pos [3];
		longint     nrm [3];
		longint     moved [3];
		longint     turned [3];
		longint     psum, nsum, k;
		pos[0] = p.pos_x;
		pos[1] = p.pos_y;
		pos[2] = p.pos_z;
		nrm[0] = p.norm_x;
		nrm[1] = p.norm_y;
		nrm[2] = p.norm_z;
		for (int row = 0; row < 3; row++) begin
			psum = 0;
			nsum = 0;
			for (int col = 0; col < 3; col++) begin
				k = pnrt_pkg::coef_t'(
					matrix_row[row][col*pnrt_pkg::COEF_WIDTH +: pnrt_pkg::COEF_WIDTH]);
				psum += pos[col] * k;
				nsum += nrm[col] * k;
			end
			moved[row]  = clamp(round_half_up(psum) + longint'(translation[row]),
				pnrt_pkg::POS_WIDTH);
			turned[row] = clamp(round_half_up(nsum), pnrt_pkg::NORM_WIDTH);
		end
		r.out_x              = pnrt_pkg::pos_t'(moved[0]);
		r.out_y              = pnrt_pkg::pos_t'(moved[1]);
		r.out_z              = pnrt_pkg::pos_t'(moved[2]);
		r.out_norm_x         = pnrt_pkg::norm_t'(turned[0]);
		r.out_norm_y         = pnrt_pkg::norm_t'(turned[1]);
		r.out_norm_z         = pnrt_pkg::norm_t'(turned[2]);
		r.out_curvature_bits = p.curvature_bits;
		r.out_red            = p.red;
		r.out_green          = p.green;
		r.out_blue           = p.blue;
		return r;
	endfunction

	function automatic string point_text(input pnrt_pkg::point_out_t q);
		return $sformatf("x %h y %h z %h n %h %h %h curv %h rgb %h %h %h",
			q.out_x, q.out_y, q.out_z, q.out_norm_x, q.out_norm_y, q.out_norm_z,
			q.out_curvature_bits, q.out_red, q.out_green, q.out_blue);
	endfunction

	// check every transformed point taken from the output channel
	always @(posedge clk) begin
		pnrt_pkg::point_out_t want;
		if (arst_n && pt_out.valid && pt_out.ready) begin
			if (expected_points.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("point with no request waiting: %s", point_text(pt_out.data));
			end else begin
				want = expected_points.pop_front();
				if (pt_out.data !== want) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("mismatch at cycle %0d", cycle_count);
						$display("  expected %s", point_text(want));
						$display("  actual   %s", point_text(pt_out.data));
					end
				end
			end
		end
		if (ready_run != 0) begin
			ready_run--;
		end else if (pt_out.ready && stall_on) begin
			pt_out.ready <= 1'b0;
			ready_run = $urandom_range(0, 7);
		end else begin
			pt_out.ready <= 1'b1;
			ready_run = $urandom_range(0, 15);
		end
	end

	task automatic write_reg(input logic [pnrt_pkg::CFG_IDX_W-1:0] idx,
		input logic [pnrt_pkg::CFG_WIDTH-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx) inside
			pnrt_pkg::REG_ROW0, pnrt_pkg::REG_ROW1, pnrt_pkg::REG_ROW2:
				matrix_row[idx[1:0]] = value;
			pnrt_pkg::REG_SHIFT_X, pnrt_pkg::REG_SHIFT_Y, pnrt_pkg::REG_SHIFT_Z:
				translation[2'(idx - pnrt_pkg::REG_SHIFT_X)] =
					value[pnrt_pkg::SHIFT_WIDTH-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_transform(input pnrt_pkg::row_t r0, input pnrt_pkg::row_t r1,
		input pnrt_pkg::row_t r2,
		input logic [pnrt_pkg::CFG_WIDTH-1:0] sx, input logic [pnrt_pkg::CFG_WIDTH-1:0] sy,
		input logic [pnrt_pkg::CFG_WIDTH-1:0] sz);
		write_reg(pnrt_pkg::REG_ROW0, r0);
		write_reg(pnrt_pkg::REG_ROW1, r1);
		write_reg(pnrt_pkg::REG_ROW2, r2);
		write_reg(pnrt_pkg::REG_SHIFT_X, sx);
		write_reg(pnrt_pkg::REG_SHIFT_Y, sy);
		write_reg(pnrt_pkg::REG_SHIFT_Z, sz);
	endtask

	task automatic send_point(input pnrt_pkg::point_in_t p);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, max_gap) : 0;
			if (gap != 0) begin
				pt_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pt_in.valid <= 1'b1;
		pt_in.data  <= p;
		do @(posedge clk); while (!pt_in.ready);
		expected_points.insert(expected_points.size(), transform_point(p));
	endtask

	// hold the sender until every request has come back
	task automatic wait_drained();
		pt_in.valid <= 1'b0;
		burst_left = 0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic pnrt_pkg::point_in_t make_point(input pnrt_pkg::pos_t x,
		input pnrt_pkg::pos_t y, input pnrt_pkg::pos_t z,
		input pnrt_pkg::norm_t nx, input pnrt_pkg::norm_t ny, input pnrt_pkg::norm_t nz,
		input logic [pnrt_pkg::CURV_WIDTH-1:0] curv,
		input logic [pnrt_pkg::CHAN_WIDTH-1:0] r, input logic [pnrt_pkg::CHAN_WIDTH-1:0] g,
		input logic [pnrt_pkg::CHAN_WIDTH-1:0] b);
		pnrt_pkg::point_in_t p;
		p.pos_x          = x;
		p.pos_y          = y;
		p.pos_z          = z;
		p.norm_x         = nx;
		p.norm_y         = ny;
		p.norm_z         = nz;
		p.curvature_bits = curv;
		p.red            = r;
		p.green          = g;
		p.blue           = b;
		return p;
	endfunction

	function automatic pnrt_pkg::pos_t edge_pos();
		case ($urandom_range(0, 4))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return 32'sd1;
			3: return -32'sd1;
			default: return '0;
		endcase
	endfunction

	function automatic pnrt_pkg::norm_t edge_norm();
		case ($urandom_range(0, 4))
			0: return NORM_MAX;
			1: return NORM_MIN;
			2: return 16'sd16384;
			3: return -16'sd16384;
			default: return '0;
		endcase
	endfunction

	function automatic pnrt_pkg::coef_t edge_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MOST_POS;
			1: return COEF_MOST_NEG;
			2: return COEF_ONE;
			3: return -COEF_ONE;
			4: return 16'sd1;
			default: return '0;
		endcase
	endfunction

	function automatic pnrt_pkg::point_in_t random_point();
		pnrt_pkg::point_in_t p;
		int unsigned style;
		style = $urandom_range(0, 9);
		if (style < 5) begin
			p.pos_x  = pnrt_pkg::pos_t'($urandom());
			p.pos_y  = pnrt_pkg::pos_t'($urandom());
			p.pos_z  = pnrt_pkg::pos_t'($urandom());
			p.norm_x = pnrt_pkg::norm_t'($urandom());
			p.norm_y = pnrt_pkg::norm_t'($urandom());
			p.norm_z = pnrt_pkg::norm_t'($urandom());
		end else if (style < 9) begin
			p.pos_x  = pnrt_pkg::pos_t'($signed($urandom()) >>> 11);
			p.pos_y  = pnrt_pkg::pos_t'($signed($urandom()) >>> 11);
			p.pos_z  = pnrt_pkg::pos_t'($signed($urandom()) >>> 11);
			p.norm_x = pnrt_pkg::norm_t'($signed($urandom()) >>> 17);
			p.norm_y = pnrt_pkg::norm_t'($signed($urandom()) >>> 17);
			p.norm_z = pnrt_pkg::norm_t'($signed($urandom()) >>> 17);
		end else begin
			p.pos_x  = edge_pos();
			p.pos_y  = edge_pos();
			p.pos_z  = edge_pos();
			p.norm_x = edge_norm();
			p.norm_y = edge_norm();
			p.norm_z = edge_norm();
		end
		p.curvature_bits = $urandom();
		p.red            = pnrt_pkg::CHAN_WIDTH'($urandom());
		p.green          = pnrt_pkg::CHAN_WIDTH'($urandom());
		p.blue           = pnrt_pkg::CHAN_WIDTH'($urandom());
		return p;
	endfunction

	function automatic pnrt_pkg::row_t random_row(input int unsigned style);
		pnrt_pkg::row_t r;
		pnrt_pkg::coef_t c;
		for (int col = 0; col < 3; col++) begin
			case (style)
				0: c = pnrt_pkg::coef_t'($urandom());
				1: c = pnrt_pkg::coef_t'($signed($urandom()) >>> 17);
				default: c = edge_coef();
			endcase
			r[col*pnrt_pkg::COEF_WIDTH +: pnrt_pkg::COEF_WIDTH] = c;
		end
		return r;
	endfunction

	function automatic logic [pnrt_pkg::CFG_WIDTH-1:0] random_shift(input int unsigned style);
		logic [15:0] junk;
		junk = 16'($urandom());
		case (style)
			0: return {junk, 32'($urandom())};
			1: return {junk, 32'($signed($urandom()) >>> 8)};
			default: return {junk, edge_pos()};
		endcase
	endfunction

	task automatic test_identity_passthrough();
		send_point(make_point(POS_MAX, POS_MAX, POS_MAX, NORM_MAX, NORM_MAX, NORM_MAX,
			32'hffff_ffff, 8'hff, 8'hff, 8'hff));
		send_point(make_point(POS_MIN, POS_MIN, POS_MIN, NORM_MIN, NORM_MIN, NORM_MIN,
			32'h0, 8'h00, 8'h00, 8'h00));
		send_point(make_point('0, '0, '0, '0, '0, '0, 32'h8000_0001, 8'h80, 8'h01, 8'h7f));
		send_point(make_point(32'sd1, -32'sd1, 32'sd65536, 16'sd1, -16'sd1, 16'sd16384,
			32'h5a5a_a5a5, 8'haa, 8'h55, 8'h0f));
		wait_drained();
	endtask

	task automatic test_saturation();
		load_transform({3{COEF_MOST_NEG}}, {3{COEF_MOST_NEG}}, {3{COEF_MOST_NEG}}, '0, '0, '0);
		send_point(make_point(POS_MAX, POS_MAX, POS_MAX, NORM_MAX, NORM_MAX, NORM_MAX,
			32'h1234_5678, 8'h12, 8'h34, 8'h56));
		send_point(make_point(POS_MIN, POS_MIN, POS_MIN, NORM_MIN, NORM_MIN, NORM_MIN,
			32'hedcb_a987, 8'hed, 8'hcb, 8'ha9));
		wait_drained();
		load_transform({3{COEF_MOST_POS}}, {3{COEF_MOST_POS}}, {3{COEF_MOST_POS}},
			{16'hffff, POS_MAX}, {16'h0000, POS_MIN}, '0);
		send_point(make_point(POS_MAX, POS_MAX, POS_MAX, NORM_MAX, NORM_MAX, NORM_MAX,
			32'h0, 8'h00, 8'hff, 8'h00));
		send_point(make_point(POS_MIN, POS_MAX, POS_MIN, NORM_MIN, NORM_MAX, NORM_MIN,
			32'hffff_ffff, 8'hff, 8'h00, 8'hff));
		send_point(make_point('0, '0, '0, '0, '0, '0, 32'h0, 8'h00, 8'h00, 8'h00));
		wait_drained();
	endtask

	// with the smallest coefficient, a position of 8192 becomes an exact half output LSB
	task automatic test_rounding_halves();
		load_transform(48'h1, 48'h1, 48'h1, '0, {16'h0, POS_MAX}, {16'h0, POS_MIN});
		send_point(make_point(32'sd8192, '0, '0, 16'sd8192, '0, '0, 32'h1, 8'h1, 8'h2, 8'h3));
		send_point(make_point(-32'sd8192, '0, '0, -16'sd8192, '0, '0, 32'h2, 8'h4, 8'h5, 8'h6));
		send_point(make_point(-32'sd8193, '0, '0, -16'sd8193, '0, '0, 32'h3, 8'h7, 8'h8, 8'h9));
		send_point(make_point(32'sd24576, '0, '0, 16'sd24576, '0, '0, 32'h4, 8'ha, 8'hb, 8'hc));
		send_point(make_point(-32'sd24576, 32'sd8191, '0, -16'sd24576, '0, '0, 32'h5,
			8'hd, 8'he, 8'hf));
		wait_drained();
	endtask

	task automatic test_register_decode();
		load_transform({COEF_MOST_POS, COEF_MOST_NEG, COEF_ONE}, {-COEF_ONE, COEF_ONE, ROW_ZERO[15:0]},
			{ROW_ZERO[15:0], 16'sd1, COEF_MOST_NEG}, {16'hbeef, 32'sd65536},
			{16'hffff, -32'sd65536}, {16'h8000, 32'sd12345});
		write_reg(REG_UNMAPPED_A, '1);
		write_reg(REG_UNMAPPED_B, 48'h8000_0000_0001);
		send_point(make_point(32'sd65536, 32'sd131072, -32'sd65536, 16'sd16384, -16'sd8192,
			16'sd100, 32'hcafe_f00d, 8'h11, 8'h22, 8'h33));
		send_point(make_point(POS_MAX, POS_MIN, 32'sd1, NORM_MAX, NORM_MIN, 16'sd1,
			32'h0bad_0bad, 8'h44, 8'h55, 8'h66));
		wait_drained();
	endtask

	task automatic test_random_streams();
		int unsigned style;
		for (int phase = 0; phase < PHASES; phase++) begin
			style    = phase % 3;
			gaps_on  = (phase != 0);
			stall_on = (phase != 0);
			max_gap  = (phase == 1) ? 8 : 3;
			load_transform(random_row(style), random_row(style), random_row(style),
				random_shift(style), random_shift(style), random_shift(style));
			if ($urandom_range(0, 1))
				write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
					{16'($urandom()), 32'($urandom())});
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
				send_point(random_point());
			wait_drained();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		pt_in.valid  = 1'b0;
		pt_in.data   = '0;
		pt_out.ready = 1'b0;
		for (int i = 0; i < 3; i++) begin
			matrix_row[i]  = pnrt_pkg::row_t'(COEF_ONE) << (i * pnrt_pkg::COEF_WIDTH);
			translation[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_on = 1'b1;
		test_identity_passthrough();
		test_saturation();
		test_rounding_halves();
		test_register_decode();
		test_random_streams();

		wait_drained();
		if (failures == 0 && expected_points.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
